// ===== rtl/core/mda_pkg.sv =====
// ----------------------------------------------------------------------------
// mda_pkg
// Shared types and constants for the multidimensional array element store.
// ----------------------------------------------------------------------------
package mda_pkg;

    localparam int NUM_INDEX = 8;   // subscripts carried by every request
    localparam int IDX_W     = 12;  // width of one subscript
    localparam int BND_W     = 13;  // width of one extent register
    localparam int CFG_IDX_W = 3;   // width of the register index
    localparam int DATA_W    = 32;  // width of the data fields
    localparam int OFF_W     = 12;  // width of the returned offset
    localparam int STAT_W    = 2;   // width of the status field

    typedef enum logic [STAT_W-1:0] {
        ST_DONE     = 2'd0,
        ST_RANGE    = 2'd1,
        ST_OVERSIZE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SUM,
        S_MEM,
        S_RESP
    } state_t;

    // One extent register write towards the stride unit.
    typedef struct packed {
        logic                 en;
        logic [CFG_IDX_W-1:0] idx;
        logic [BND_W-1:0]     data;
    } cfg_wr_t;

    // State of the stride unit as seen by the access path.
    typedef struct packed {
        logic busy;
        logic oversize;
    } stride_stat_t;

endpackage

// ===== rtl/core/multidim_array_access.sv =====
// ----------------------------------------------------------------------------
// multidim_array_access
// Row-major element store for an array of up to eight dimensions.
// ----------------------------------------------------------------------------
// A request is taken only in the idle state. The accepting edge registers the
// per-dimension stride products and range checks, the sum state adds the
// products into the offset, the memory state performs the memory access and
// the response state loads the result into the result register, waiting there
// while the result register is full and stalled. The element memory is
// single-port with registered read data. One request is in flight at a time
// and the next can be taken on the cycle after the result is loaded. The
// result register lets a new request be taken while the previous result
// waits. A write of an extent register re-derives the row strides one
// dimension per cycle, so requests and further register writes are held off
// until the derivation is complete. The element memory has no reset; an
// element must be written before it is read.
module multidim_array_access #(
    parameter int MAX_DIMS      = 8,
    parameter int STORE_DEPTH   = 4096,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mda_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mda_pkg::BND_W-1:0]       cfg_data,
    // request
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            mode,
    input  logic [mda_pkg::IDX_W-1:0]       index_0,
    input  logic [mda_pkg::IDX_W-1:0]       index_1,
    input  logic [mda_pkg::IDX_W-1:0]       index_2,
    input  logic [mda_pkg::IDX_W-1:0]       index_3,
    input  logic [mda_pkg::IDX_W-1:0]       index_4,
    input  logic [mda_pkg::IDX_W-1:0]       index_5,
    input  logic [mda_pkg::IDX_W-1:0]       index_6,
    input  logic [mda_pkg::IDX_W-1:0]       index_7,
    input  logic [mda_pkg::DATA_W-1:0]      write_data,
    // result
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [mda_pkg::STAT_W-1:0]      status,
    output logic [mda_pkg::OFF_W-1:0]       element_offset,
    output logic [mda_pkg::DATA_W-1:0]      read_data
);

    localparam int SW = $clog2(STORE_DEPTH + 2);
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int MW = SW + mda_pkg::IDX_W;

    mda_pkg::cfg_wr_t                          cfg_wr;
    mda_pkg::stride_stat_t                     stride_stat;
    logic [MAX_DIMS-1:0][SW-1:0]               strides;
    logic [MAX_DIMS-1:0][mda_pkg::BND_W-1:0]   bounds;

    mda_pkg::state_t  state_reg, state_next;
    logic             in_acc;
    logic             cfg_acc;
    logic             mem_en;
    logic             mem_we;
    logic             out_load;

    logic [mda_pkg::IDX_W-1:0]     idx_in    [mda_pkg::NUM_INDEX];
    logic [AW-1:0]                 prod_next [mda_pkg::NUM_INDEX];
    logic [AW-1:0]                 prod_reg  [mda_pkg::NUM_INDEX];
    logic [mda_pkg::NUM_INDEX-1:0] range_hit;
    logic [AW-1:0]                 off_sum;
    logic [AW-1:0]                 off_reg;
    logic                          mode_reg;
    logic [mda_pkg::DATA_W-1:0]    wdata_reg;
    mda_pkg::status_t              status_reg;
    mda_pkg::status_t              status_next;
    logic [ELEMENT_WIDTH-1:0]      rd_data;

    logic                          out_valid_reg;
    mda_pkg::status_t              out_status_reg;
    logic [mda_pkg::OFF_W-1:0]     out_offset_reg;
    logic [mda_pkg::DATA_W-1:0]    out_data_reg;

    assign idx_in[0] = index_0;
    assign idx_in[1] = index_1;
    assign idx_in[2] = index_2;
    assign idx_in[3] = index_3;
    assign idx_in[4] = index_4;
    assign idx_in[5] = index_5;
    assign idx_in[6] = index_6;
    assign idx_in[7] = index_7;

    assign cfg_acc   = cfg_valid && cfg_ready;
    assign in_acc    = in_valid && !in_stall;

    assign cfg_wr.en   = cfg_acc;
    assign cfg_wr.idx  = cfg_index;
    assign cfg_wr.data = cfg_data;

    mda_strides #(
        .MAX_DIMS    (MAX_DIMS),
        .STORE_DEPTH (STORE_DEPTH),
        .SW          (SW)
    ) u_strides (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_wr  (cfg_wr),
        .stat    (stride_stat),
        .strides (strides),
        .bounds  (bounds)
    );

    // Per-dimension lanes. Only the low address bits of each product matter,
    // as a request that passes the checks always lands inside the store.
    for (genvar g = 0; g < mda_pkg::NUM_INDEX; g++)
    begin : g_lane
        if (g < MAX_DIMS)
        begin : g_used
            assign prod_next[g] = AW'(MW'(strides[g]) * MW'(idx_in[g]));
            assign range_hit[g] = ({1'b0, idx_in[g]} >= bounds[g]);
        end
        else
        begin : g_unused
            assign prod_next[g] = '0;
            assign range_hit[g] = 1'b0;
        end
    end

    always_comb
    begin
        if (stride_stat.oversize)
        begin
            status_next = mda_pkg::ST_OVERSIZE;
        end
        else if (|range_hit)
        begin
            status_next = mda_pkg::ST_RANGE;
        end
        else
        begin
            status_next = mda_pkg::ST_DONE;
        end
    end

    always_comb
    begin
        off_sum = '0;
        for (int d = 0; d < mda_pkg::NUM_INDEX; d++)
        begin
            off_sum = off_sum + prod_reg[d];
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mda_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = mda_pkg::S_SUM;
                end
            end
            mda_pkg::S_SUM:
            begin
                state_next = mda_pkg::S_MEM;
            end
            mda_pkg::S_MEM:
            begin
                state_next = mda_pkg::S_RESP;
            end
            mda_pkg::S_RESP:
            begin
                if (out_load)
                begin
                    state_next = mda_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mda_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs of the state machine
    always_comb
    begin
        cfg_ready = 1'b0;
        in_stall  = 1'b1;
        mem_en    = 1'b0;
        mem_we    = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            mda_pkg::S_IDLE:
            begin
                // A pending register write goes ahead of a request.
                cfg_ready = !stride_stat.busy;
                in_stall  = stride_stat.busy || cfg_valid;
            end
            mda_pkg::S_MEM:
            begin
                mem_en = (status_reg == mda_pkg::ST_DONE);
                mem_we = (status_reg == mda_pkg::ST_DONE) && mode_reg;
            end
            mda_pkg::S_RESP:
            begin
                out_load = !out_valid_reg || !out_stall;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mda_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            prod_reg   <= prod_next;
            mode_reg   <= mode;
            wdata_reg  <= write_data;
            status_reg <= status_next;
        end
        if (state_reg == mda_pkg::S_SUM)
        begin
            off_reg <= off_sum;
        end
        if (out_load)
        begin
            out_status_reg <= status_reg;
            if (status_reg == mda_pkg::ST_DONE)
            begin
                out_offset_reg <= mda_pkg::OFF_W'(off_reg);
                out_data_reg   <= mode_reg ? '0 : mda_pkg::DATA_W'(rd_data);
            end
            else
            begin
                out_offset_reg <= '0;
                out_data_reg   <= '0;
            end
        end
    end

    mda_store #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (ELEMENT_WIDTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (off_reg),
        .wdata (ELEMENT_WIDTH'(wdata_reg)),
        .rdata (rd_data)
    );

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign element_offset = out_offset_reg;
    assign read_data      = out_data_reg;

    // Assertions

    a_no_req_while_deriving: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> !stride_stat.busy)
        else $error("request taken while strides were being derived");

    a_req_enters_sum: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == mda_pkg::S_SUM))
        else $error("accepted request did not move on to the offset sum");

    a_write_only_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (status_reg == mda_pkg::ST_DONE))
        else $error("element written for a refused request");

    a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == mda_pkg::S_RESP))
        else $error("result appeared without a completed request");

endmodule

// ===== rtl/core/mda_strides.sv =====
// ----------------------------------------------------------------------------
// mda_strides
// Extent registers and row stride derivation, one saturating product a cycle.
// ----------------------------------------------------------------------------
module mda_strides #(
    parameter int MAX_DIMS    = 8,
    parameter int STORE_DEPTH = 4096,
    parameter int SW          = 13
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  mda_pkg::cfg_wr_t                          cfg_wr,
    output mda_pkg::stride_stat_t                     stat,
    output logic [MAX_DIMS-1:0][SW-1:0]               strides,
    output logic [MAX_DIMS-1:0][mda_pkg::BND_W-1:0]   bounds
);

    localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int XW = (SW > mda_pkg::BND_W) ? SW : mda_pkg::BND_W;
    localparam int PW = 2 * SW;
    localparam logic [SW-1:0] CAP       = SW'(STORE_DEPTH + 1);
    localparam logic [SW-1:0] DEPTH_LIM = SW'(STORE_DEPTH);

    logic [mda_pkg::BND_W-1:0] bound_reg  [MAX_DIMS];
    logic [mda_pkg::BND_W-1:0] bound_next [MAX_DIMS];
    logic [SW-1:0]             stride_reg  [MAX_DIMS];
    logic [SW-1:0]             stride_next [MAX_DIMS];
    logic [SW-1:0]             acc_reg, acc_next;
    logic [DW-1:0]             cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      over_reg, over_next;

    logic [SW-1:0] bnd_sat;
    logic [PW-1:0] prod_full;
    logic [SW-1:0] prod_sat;

    // Saturating product of the running stride and the extent under the counter.
    always_comb
    begin
        bnd_sat   = (XW'(bound_reg[cnt_reg]) > XW'(CAP)) ? CAP : SW'(bound_reg[cnt_reg]);
        prod_full = PW'(acc_reg) * PW'(bnd_sat);
        prod_sat  = (prod_full > PW'(CAP)) ? CAP : SW'(prod_full);
    end

    always_comb
    begin
        bound_next  = bound_reg;
        stride_next = stride_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        over_next   = over_reg;
        if (cfg_wr.en)
        begin
            for (int d = 0; d < MAX_DIMS; d++)
            begin
                if (cfg_wr.idx == mda_pkg::CFG_IDX_W'(d))
                begin
                    bound_next[d] = cfg_wr.data;
                end
            end
            busy_next = 1'b1;
            cnt_next  = DW'(MAX_DIMS - 1);
            acc_next  = SW'(1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                // The product over dimensions from cnt upward is the stride of dimension cnt-1.
                for (int d = 0; d < MAX_DIMS - 1; d++)
                begin
                    if (cnt_reg == DW'(d + 1))
                    begin
                        stride_next[d] = prod_sat;
                    end
                end
                acc_next = prod_sat;
                cnt_next = cnt_reg - 1'b1;
            end
            else
            begin
                over_next = (prod_sat > DEPTH_LIM);
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < MAX_DIMS; d++)
            begin
                bound_reg[d]  <= mda_pkg::BND_W'(1);
                stride_reg[d] <= SW'(1);
            end
            acc_reg  <= SW'(1);
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            over_reg <= 1'b0;
        end
        else
        begin
            bound_reg  <= bound_next;
            stride_reg <= stride_next;
            acc_reg    <= acc_next;
            cnt_reg    <= cnt_next;
            busy_reg   <= busy_next;
            over_reg   <= over_next;
        end
    end

    always_comb
    begin
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            strides[d] = stride_reg[d];
            bounds[d]  = bound_reg[d];
        end
        stat.busy     = busy_reg;
        stat.oversize = over_reg;
    end

endmodule

// ===== rtl/core/mda_store.sv =====
// ----------------------------------------------------------------------------
// mda_store
// Single-port element memory with registered read data.
// ----------------------------------------------------------------------------
module mda_store #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 32,
    parameter int AW    = 12
) (
    input  logic             clk,
    input  logic             en,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en && we)
        begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && !we)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
